/* rtl/core/window_pacing_rate_core_assert.svh */
// Assertion macros shared by the pacing rate core
`ifndef WINDOW_PACING_RATE_CORE_ASSERT_SVH
`define WINDOW_PACING_RATE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define WPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/wpr_pkg.sv */
`timescale 1ns / 1ps
package wpr_pkg;

  localparam int DIVD_W     = 62;   // window * 1e9 fits in 62 bits
  localparam int NOS_W      = 55;   // window * 8e6 fits in 55 bits
  localparam int GAIN_W     = 9;
  localparam int REM_W      = 7;    // remainder of a division by 100
  localparam int DEC_STAGES = 8;
  localparam int DEC_BITS   = 8;
  localparam int QV_W       = DEC_STAGES * DEC_BITS;
  localparam int RG_W       = REM_W + GAIN_W;
  localparam int RECIP_W    = 17;
  localparam int RECIP_SH   = 23;
  localparam int ADDR_W     = 5;

  localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
  localparam logic [22:0] NO_SRTT_SCALE = 23'd8000000;
  localparam logic [REM_W-1:0]   PCT_DIV  = 7'd100;
  localparam logic [RECIP_W-1:0] RECIP100 = 17'd83887;   // ceil(2^23 / 100)

  localparam logic [1:0] REG_SS_GAIN = 2'd0;
  localparam logic [1:0] REG_CA_GAIN = 2'd1;
  localparam logic [1:0] REG_CAP     = 2'd2;

  localparam logic [GAIN_W-1:0] SS_GAIN_RST = 9'd200;
  localparam logic [GAIN_W-1:0] CA_GAIN_RST = 9'd120;

  typedef struct packed {
    logic [31:0] window_bytes_in;
    logic [31:0] inflight_bytes_in;
    logic [31:0] threshold_bytes;
    logic [63:0] rtt_ns;
    logic [63:0] existing_rate;
  } req_t;

  typedef struct packed {
    logic [63:0] pacing_rate;
    logic        kept_existing;
  } rsp_t;

  // per-request fields carried alongside the arithmetic
  typedef struct packed {
    logic              kept;
    logic [63:0]       existing;
    logic              win_zero;
    logic              srtt_zero;
    logic [NOS_W-1:0]  nos;
    logic [GAIN_W-1:0] gain;
  } side_t;

endpackage

/* rtl/core/wpr_div.sv */
`timescale 1ns / 1ps
module wpr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [wpr_pkg::DIVD_W-1:0]  in_dvd,
  input  logic [63:0]                 in_dvs,
  input  wpr_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [wpr_pkg::DIVD_W-1:0]  out_quot,
  output wpr_pkg::side_t              out_side
);
  import wpr_pkg::*;

  // one quotient bit per stage, restoring
  logic [DIVD_W-1:0] vld;
  logic [63:0]       rem     [DIVD_W];
  logic [DIVD_W-1:0] dq      [DIVD_W];
  logic [63:0]       dvs     [DIVD_W];
  side_t             sd      [DIVD_W];
  logic [63:0]       rem_nxt [DIVD_W];
  logic [DIVD_W-1:0] dq_nxt  [DIVD_W];

  always_comb begin
    logic [64:0]       trial;
    logic [63:0]       r_src;
    logic [DIVD_W-1:0] q_src;
    logic [63:0]       d_src;
    for (int k = 0; k < DIVD_W; k++) begin
      r_src = (k == 0) ? 64'd0 : rem[k-1];
      q_src = (k == 0) ? in_dvd : dq[k-1];
      d_src = (k == 0) ? in_dvs : dvs[k-1];
      trial = {r_src, q_src[DIVD_W-1]};
      if (trial >= {1'b0, d_src}) begin
        rem_nxt[k] = 64'(trial - {1'b0, d_src});
        dq_nxt[k]  = {q_src[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[63:0];
        dq_nxt[k]  = {q_src[DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DIVD_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIVD_W; k++) begin
        rem[k] <= rem_nxt[k];
        dq[k]  <= dq_nxt[k];
        dvs[k] <= (k == 0) ? in_dvs : dvs[k-1];
        sd[k]  <= (k == 0) ? in_side : sd[k-1];
      end
    end
  end

  assign out_vld  = vld[DIVD_W-1];
  assign out_quot = dq[DIVD_W-1];
  assign out_side = sd[DIVD_W-1];

endmodule

/* rtl/core/wpr_pct.sv */
`timescale 1ns / 1ps
module wpr_pct (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [wpr_pkg::DIVD_W-1:0]  in_quot,
  input  wpr_pkg::side_t              in_side,
  input  logic [63:0]                 cap,
  output logic                        out_vld,
  output wpr_pkg::rsp_t               out_rsp
);
  import wpr_pkg::*;

  localparam int NST = DEC_STAGES + 4;
  localparam int DN_W = REM_W + DEC_BITS;
  localparam int DP_W = DN_W + RECIP_W;

  logic [NST-1:0] vld;

  // base select
  logic [QV_W-1:0]  p0_v;
  side_t            p0_sd;
  // digit stages of the division by 100
  logic [QV_W-1:0]  dx      [DEC_STAGES];
  logic [REM_W-1:0] dr      [DEC_STAGES];
  side_t            dsd     [DEC_STAGES];
  logic [QV_W-1:0]  dx_nxt  [DEC_STAGES];
  logic [REM_W-1:0] dr_nxt  [DEC_STAGES];
  // gain products
  logic [QV_W+GAIN_W-1:0] g1_hi;
  logic [RG_W-1:0]        g1_rg;
  side_t                  g1_sd;
  logic [QV_W+GAIN_W-1:0] g2_hi;
  logic [9:0]             g2_lo;
  side_t                  g2_sd;
  rsp_t                   rsp;

  logic [QV_W-1:0]              base;
  logic [RG_W+RECIP_W-1:0]      lo_prod;
  logic [QV_W+GAIN_W:0]         sum;
  logic [63:0]                  gained;
  logic [63:0]                  capped;

  always_comb begin
    if (in_side.srtt_zero) begin
      base = QV_W'(in_side.nos);
    end else if (in_quot == '0) begin
      base = QV_W'(1);
    end else begin
      base = QV_W'(in_quot);
    end
  end

  // one byte digit per stage: remainder and next byte divided by 100 via the reciprocal
  always_comb begin
    logic [DN_W-1:0]     n;
    logic [DP_W-1:0]     np;
    logic [DEC_BITS-1:0] qd;
    logic [REM_W-1:0]    r;
    logic [QV_W-1:0]     x;
    for (int s = 0; s < DEC_STAGES; s++) begin
      r  = (s == 0) ? '0 : dr[s-1];
      x  = (s == 0) ? p0_v : dx[s-1];
      n  = {r, x[QV_W-1 -: DEC_BITS]};
      np = DP_W'(n) * DP_W'(RECIP100);
      qd = DEC_BITS'(np >> RECIP_SH);
      r  = REM_W'(n - DN_W'(qd) * DN_W'(PCT_DIV));
      x  = {x[QV_W-DEC_BITS-1:0], qd};
      dr_nxt[s] = r;
      dx_nxt[s] = x;
    end
  end

  assign lo_prod = g1_rg * RECIP100;
  assign sum     = (QV_W+GAIN_W+1)'(g2_hi) + (QV_W+GAIN_W+1)'(g2_lo);

  always_comb begin
    if (g2_sd.gain == '0) begin
      gained = '0;
    end else if (sum[QV_W+GAIN_W:64] != '0) begin
      gained = '1;
    end else if (sum == '0) begin
      gained = 64'd1;
    end else begin
      gained = sum[63:0];
    end
    if (g2_sd.win_zero) begin
      gained = '0;
    end
    capped = (cap != '0 && gained > cap) ? cap : gained;
    if (g2_sd.kept) begin
      rsp.pacing_rate   = g2_sd.existing;
      rsp.kept_existing = 1'b1;
    end else begin
      rsp.pacing_rate   = capped;
      rsp.kept_existing = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_v  <= base;
      p0_sd <= in_side;
      for (int s = 0; s < DEC_STAGES; s++) begin
        dx[s]  <= dx_nxt[s];
        dr[s]  <= dr_nxt[s];
        dsd[s] <= (s == 0) ? p0_sd : dsd[s-1];
      end
      g1_hi   <= dx[DEC_STAGES-1] * dsd[DEC_STAGES-1].gain;
      g1_rg   <= dr[DEC_STAGES-1] * dsd[DEC_STAGES-1].gain;
      g1_sd   <= dsd[DEC_STAGES-1];
      g2_hi   <= g1_hi;
      g2_lo   <= lo_prod[RG_W+RECIP_W-1:RECIP_SH];
      g2_sd   <= g1_sd;
      out_rsp <= rsp;
    end
  end

  assign out_vld = vld[NST-1];

endmodule

/* rtl/core/window_pacing_rate_core.sv */
`timescale 1ns / 1ps
// channel | role           | handshake               | payload
// req     | connection in  | req_valid / req_ready   | req_data  (wpr_pkg::req_t)
// rsp     | rate out       | rsp_valid / rsp_ready   | rsp_data  (wpr_pkg::rsp_t)
// apb     | register port  | psel/penable/pwrite     | paddr, pwdata, prdata
//
// Takes one request per cycle unless rsp stalls. Each answer passes through 1 entry
// stage, 62 stages of the bit-serial divider by RTT (one quotient bit per stage over
// 62 bits) and 12 stages of base select, division by 100, gain and cap.
// rst is synchronous; it clears the stage valid bits and resets the config registers.
// A stall on rsp freezes the whole pipeline at once; nothing is dropped.
module window_pacing_rate_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  wpr_pkg::req_t               req_data,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output wpr_pkg::rsp_t               rsp_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wpr_pkg::ADDR_W-1:0]  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import wpr_pkg::*;
`include "window_pacing_rate_core_assert.svh"

  // configuration registers
  logic [GAIN_W-1:0] ss_gain;
  logic [GAIN_W-1:0] ca_gain;
  logic [63:0]       rate_cap;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ss_gain  <= SS_GAIN_RST;
      ca_gain  <= CA_GAIN_RST;
      rate_cap <= '0;
    end else if (wr_en) begin
      case (paddr[4:3])
        REG_SS_GAIN: ss_gain  <= pwdata[GAIN_W-1:0];
        REG_CA_GAIN: ca_gain  <= pwdata[GAIN_W-1:0];
        REG_CAP:     rate_cap <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_SS_GAIN: prdata = 64'(ss_gain);
      REG_CA_GAIN: prdata = 64'(ca_gain);
      REG_CAP:     prdata = rate_cap;
      default:     prdata = '0;
    endcase
  end

  // advance every stage whenever the output register is free or being read
  logic adv;
  assign adv       = ~rsp_valid | rsp_ready;
  assign req_ready = adv;

  // entry stage: window, scaled dividend, no-sample rate and gain choice
  logic [31:0]       win;
  logic [DIVD_W-1:0] dvd;
  side_t             side;

  logic              e_vld;
  logic [DIVD_W-1:0] e_dvd;
  logic [63:0]       e_dvs;
  side_t             e_side;

  always_comb begin
    win = (req_data.inflight_bytes_in > req_data.window_bytes_in) ?
          req_data.inflight_bytes_in : req_data.window_bytes_in;
    dvd            = DIVD_W'(win) * DIVD_W'(NS_PER_SEC);
    side.kept      = req_data.existing_rate != '0;
    side.existing  = req_data.existing_rate;
    side.win_zero  = win == '0;
    side.srtt_zero = req_data.rtt_ns == '0;
    side.nos       = NOS_W'(win) * NOS_W'(NO_SRTT_SCALE);
    // slow start while cwnd sits below half the threshold
    side.gain      = (req_data.window_bytes_in < (req_data.threshold_bytes >> 1)) ?
                     ss_gain : ca_gain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_dvd  <= dvd;
      e_dvs  <= req_data.rtt_ns;
      e_side <= side;
    end
  end

  logic              d_vld;
  logic [DIVD_W-1:0] d_quot;
  side_t             d_side;

  wpr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (e_vld),
    .in_dvd   (e_dvd),
    .in_dvs   (e_dvs),
    .in_side  (e_side),
    .out_vld  (d_vld),
    .out_quot (d_quot),
    .out_side (d_side)
  );

  wpr_pct u_pct (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (d_vld),
    .in_quot  (d_quot),
    .in_side  (d_side),
    .cap      (rate_cap),
    .out_vld  (rsp_valid),
    .out_rsp  (rsp_data)
  );

  `WPR_ASSERT_NOW(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready, "request taken during stall")
  `WPR_ASSERT_NOW(a_kept_nonzero, rsp_valid && rsp_data.kept_existing, rsp_data.pacing_rate != 64'd0, "kept rate is zero")
  `WPR_ASSERT_NOW(a_cap_holds, rsp_valid && !rsp_data.kept_existing && rate_cap != 64'd0, rsp_data.pacing_rate <= rate_cap, "rate above cap")
  `WPR_ASSERT_NEXT(a_stall_freezes_entry, !adv, $stable(e_vld), "entry stage moved in stall")

endmodule
